/* hdl/dwrm_pkg.sv */
// Shared request and status codes and the controller-to-datapath interface types.
`default_nettype none
package dwrm_pkg;

  localparam logic [1:0] REQ_ADD        = 2'd0;
  localparam logic [1:0] REQ_REMOVE_MAX = 2'd1;
  localparam logic [1:0] REQ_DUMP       = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ONE   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int VAL_W = 32;

  typedef struct packed {
    logic       latch;
    logic       add_do;
    logic       scan_start;
    logic       scan_step;
    logic       shift_start;
    logic       shift_step;
    logic       dump_start;
    logic       dump_rd;
    logic       dump_ld;
    logic       emit;
    logic       emit_best;
    logic [1:0] emit_st;
  } dwrm_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       cnt_zero;
    logic       cnt_one;
    logic       full;
    logic       scan_done;
    logic       shift_done;
    logic       dump_last;
    logic       out_free;
  } dwrm_sts_t;

endpackage
`default_nettype wire

/* hdl/deque_with_remove_max.sv */
// Top level: bounded deque of signed values with remove-max and dump requests.
// One request is handled at a time; the next is taken once the last result of
// the current one sits in the output register. Remove-max scans all elements
// for the maximum, then moves the elements behind it one slot toward the front
// to close the gap: the scan and the gap shift each move one slot per cycle
// through the single read port of the slot RAM. A dump walks the elements one
// at a time, each through the registered RAM read between the walk pointer and
// the output register, and waits for the output register to be free before
// each read. The slot RAM needs no clearing after reset; only data read from
// occupied slots is ever used.
`default_nettype none
module deque_with_remove_max #(
  parameter int DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value_in
  input  wire  [2:0]  in_tuser,   // [1:0] req_type, [2] from_front
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  dwrm_pkg::dwrm_cmd_t cmd;
  dwrm_pkg::dwrm_sts_t sts;

  dwrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwrm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_tuser[1:0]),
    .in_front   (in_tuser[2]),
    .in_value   (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire

/* hdl/dwrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dwrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/dwrm_dp.sv */
// Datapath: queue pointers, slot store, max scan, gap shift, dump walk and output register.
`default_nettype none
module dwrm_dp #(
  parameter int DEPTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire dwrm_pkg::dwrm_cmd_t     cmd,
  output dwrm_pkg::dwrm_sts_t          sts,
  input  wire  [1:0]                   in_req,
  input  wire                          in_front,
  input  wire  [dwrm_pkg::VAL_W-1:0]   in_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [dwrm_pkg::VAL_W-1:0]   out_value,
  output logic [1:0]                   out_status,
  output logic                         out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int VW = dwrm_pkg::VAL_W;

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

  function automatic logic [AW-1:0] pos_of(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [1:0]           req_r, req_nxt;
  logic                 front_r, front_nxt;
  logic [VW-1:0]        value_r, value_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        rpos_r, rpos_nxt;
  logic [AW-1:0]        wpos_r, wpos_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic                 dv_r, dv_nxt;
  logic [AW-1:0]        dk_r, dk_nxt;
  logic [AW-1:0]        dpos_r, dpos_nxt;
  logic signed [VW-1:0] best_r, best_nxt;
  logic [AW-1:0]        best_k_r, best_k_nxt;
  logic [AW-1:0]        best_pos_r, best_pos_nxt;
  logic                 back_r, back_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VW-1:0]        out_value_r, out_value_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [VW-1:0]        wr_data;
  logic [VW-1:0]        rd_data;

  dwrm_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rpos_r),
    .rd_data (rd_data)
  );

  always_comb begin
    req_nxt        = req_r;
    front_nxt      = front_r;
    value_nxt      = value_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    rpos_nxt       = rpos_r;
    wpos_nxt       = wpos_r;
    iss_nxt        = iss_r;
    left_nxt       = left_r;
    dv_nxt         = dv_r;
    dk_nxt         = dk_r;
    dpos_nxt       = dpos_r;
    best_nxt       = best_r;
    best_k_nxt     = best_k_r;
    best_pos_nxt   = best_pos_r;
    back_nxt       = back_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = wpos_r;
    wr_data        = rd_data;

    if (cmd.latch) begin
      req_nxt   = in_req;
      front_nxt = in_front;
      value_nxt = in_value;
    end

    if (cmd.add_do) begin
      wr_en   = 1'b1;
      wr_data = value_r;
      if (front_r) begin
        head_nxt = dec_wrap(head_r);
        wr_addr  = dec_wrap(head_r);
      end else begin
        wr_addr = pos_of(head_r, cnt_r);
      end
      cnt_nxt = cnt_r + 1'b1;
    end

    if (cmd.scan_start) begin
      rpos_nxt = head_r;
      iss_nxt  = '0;
      dv_nxt   = 1'b0;
    end

    if (cmd.scan_step) begin
      if (iss_r != cnt_r) begin
        rpos_nxt = inc_wrap(rpos_r);
        iss_nxt  = iss_r + 1'b1;
        dv_nxt   = 1'b1;
        dk_nxt   = iss_r[AW-1:0];
        dpos_nxt = rpos_r;
      end else begin
        dv_nxt = 1'b0;
      end
      if (dv_r && (dk_r == '0 || $signed(rd_data) >= best_r)) begin
        best_nxt     = $signed(rd_data);
        best_k_nxt   = dk_r;
        best_pos_nxt = dpos_r;
      end
    end

    if (cmd.shift_start) begin
      wpos_nxt = best_pos_r;
      rpos_nxt = inc_wrap(best_pos_r);
      left_nxt = cnt_r - CW'(1) - CW'(best_k_r);
      cnt_nxt  = cnt_r - 1'b1;
      dv_nxt   = 1'b0;
    end

    if (cmd.shift_step) begin
      if (left_r != '0) begin
        rpos_nxt = inc_wrap(rpos_r);
        left_nxt = left_r - 1'b1;
        dv_nxt   = 1'b1;
      end else begin
        dv_nxt = 1'b0;
      end
      if (dv_r) begin
        wr_en    = 1'b1;
        wr_addr  = wpos_r;
        wr_data  = rd_data;
        wpos_nxt = inc_wrap(wpos_r);
      end
    end

    if (cmd.dump_start) begin
      left_nxt = cnt_r;
      back_nxt = !front_r;
      rpos_nxt = front_r ? head_r : pos_of(head_r, cnt_r - CW'(1));
    end

    if (cmd.dump_rd) begin
      rpos_nxt = back_r ? dec_wrap(rpos_r) : inc_wrap(rpos_r);
      left_nxt = left_r - 1'b1;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = cmd.emit_best ? best_r : '0;
      out_status_nxt = cmd.emit_st;
      out_last_nxt   = 1'b1;
    end

    if (cmd.dump_ld) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = rd_data;
      out_status_nxt = dwrm_pkg::ST_OK;
      out_last_nxt   = (left_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    front_r      <= front_nxt;
    value_r      <= value_nxt;
    rpos_r       <= rpos_nxt;
    wpos_r       <= wpos_nxt;
    iss_r        <= iss_nxt;
    left_r       <= left_nxt;
    dk_r         <= dk_nxt;
    dpos_r       <= dpos_nxt;
    best_r       <= best_nxt;
    best_k_r     <= best_k_nxt;
    best_pos_r   <= best_pos_nxt;
    back_r       <= back_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    sts.req_type   = req_r;
    sts.cnt_zero   = (cnt_r == '0);
    sts.cnt_one    = (cnt_r == CW'(1));
    sts.full       = (cnt_r == CW'(DEPTH));
    sts.scan_done  = (iss_r == cnt_r) && !dv_r;
    sts.shift_done = (left_r == '0) && !dv_r;
    sts.dump_last  = (left_r == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

/* hdl/dwrm_ctrl.sv */
// Controller state machine that sequences add, remove-max and dump requests.
`default_nettype none
module dwrm_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire dwrm_pkg::dwrm_sts_t sts,
  output dwrm_pkg::dwrm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_EMIT     = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SHIFT    = 3'd4;
  localparam logic [2:0] S_EMIT_MAX = 3'd5;
  localparam logic [2:0] S_DUMP_RD  = 3'd6;
  localparam logic [2:0] S_DUMP_LD  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req_type)
          dwrm_pkg::REQ_ADD: begin
            if (sts.full) begin
              code_nxt = dwrm_pkg::ST_FULL;
            end else begin
              cmd.add_do = 1'b1;
              code_nxt   = dwrm_pkg::ST_OK;
            end
            state_nxt = S_EMIT;
          end
          dwrm_pkg::REQ_REMOVE_MAX: begin
            if (sts.cnt_zero) begin
              code_nxt  = dwrm_pkg::ST_EMPTY;
              state_nxt = S_EMIT;
            end else if (sts.cnt_one) begin
              code_nxt  = dwrm_pkg::ST_ONE;
              state_nxt = S_EMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          dwrm_pkg::REQ_DUMP: begin
            if (sts.cnt_zero) begin
              code_nxt  = dwrm_pkg::ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.dump_start = 1'b1;
              state_nxt      = S_DUMP_RD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = code_r;
          state_nxt   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = S_EMIT_MAX;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_EMIT_MAX: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_best = 1'b1;
          cmd.emit_st   = dwrm_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        if (sts.out_free) begin
          cmd.dump_rd = 1'b1;
          state_nxt   = S_DUMP_LD;
        end
      end
      S_DUMP_LD: begin
        cmd.dump_ld = 1'b1;
        state_nxt   = sts.dump_last ? S_IDLE : S_DUMP_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= dwrm_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule
`default_nettype wire
